// File: hw/rtl/stereo_ducker_mixer_assert.svh
// -----------------------------------------------------------------------------
// stereo_ducker_mixer_assert.svh
// Assertion macros shared by the ducker/mixer RTL.
// -----------------------------------------------------------------------------
`ifndef STEREO_DUCKER_MIXER_ASSERT_SVH
`define STEREO_DUCKER_MIXER_ASSERT_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define SDM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define SDM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/sdm_pkg.sv
// -----------------------------------------------------------------------------
// sdm_pkg
// Types and constants for the stereo ducker/mixer.
// -----------------------------------------------------------------------------
package sdm_pkg;

  // digit-serial multiplier: 18-bit signed multiplicand, 16-bit unsigned
  // multiplier consumed one 4-bit digit per cycle
  localparam int unsigned MCAND_W   = 18;
  localparam int unsigned MPLIER_W  = 16;
  localparam int unsigned DIGIT_W   = 4;
  localparam int unsigned MUL_STEPS = MPLIER_W / DIGIT_W;
  localparam int unsigned STEP_W    = $clog2(MUL_STEPS);
  localparam int unsigned HI_W      = MCAND_W + DIGIT_W;
  localparam int unsigned PROD_W    = MCAND_W + MPLIER_W;

  localparam logic [15:0] ONE_Q15 = 16'h8000;

  // configuration register indexes
  localparam logic [1:0] REG_ATTACK  = 2'd0;
  localparam logic [1:0] REG_RELEASE = 2'd1;
  localparam logic [1:0] REG_DUCK    = 2'd2;
  localparam logic [1:0] REG_WET     = 2'd3;

  localparam logic [15:0] ATTACK_RST  = 16'd136;
  localparam logic [15:0] RELEASE_RST = 16'd14;
  localparam logic [15:0] DUCK_RST    = 16'd0;
  localparam logic [15:0] WET_RST     = 16'd16384;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ENV_GO,
    ST_ENV_WAIT,
    ST_SCL_GO,
    ST_SCL_WAIT,
    ST_DUCK_GO,
    ST_DUCK_WAIT,
    ST_MIX_GO,
    ST_MIX_WAIT,
    ST_PUSH
  } state_t;

  typedef struct packed {
    logic                       start;
    logic signed [MCAND_W-1:0]  mcand;
    logic        [MPLIER_W-1:0] mplier;
  } mul_req_t;

  typedef struct packed {
    logic                      done;
    logic signed [PROD_W-1:0]  prod;
  } mul_rsp_t;

endpackage

// File: hw/rtl/sdm_mul.sv
// -----------------------------------------------------------------------------
// sdm_mul
// Digit-serial multiplier: signed multiplicand times unsigned multiplier,
// one 4-bit multiplier digit per cycle, product shifts out to the right.
// -----------------------------------------------------------------------------
`include "stereo_ducker_mixer_assert.svh"

module sdm_mul import sdm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  mul_req_t req,
  output mul_rsp_t rsp
);

  logic                       busy;
  logic                       done;
  logic [STEP_W-1:0]          cnt;
  logic signed [MCAND_W-1:0]  mcand;
  logic signed [HI_W-1:0]     acc_hi;
  logic        [MPLIER_W-1:0] acc_lo;

  logic signed [HI_W:0]       pp;
  logic signed [HI_W-1:0]     sum;
  logic signed [HI_W-1:0]     sum_sh;

  always_comb begin
    pp     = mcand * $signed({1'b0, acc_lo[DIGIT_W-1:0]});
    sum    = acc_hi + $signed(pp[HI_W-1:0]);
    sum_sh = sum >>> DIGIT_W;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == STEP_W'(MUL_STEPS - 1));
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == STEP_W'(MUL_STEPS - 1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      mcand  <= req.mcand;
      acc_hi <= '0;
      acc_lo <= req.mplier;
    end else if (busy) begin
      acc_hi <= sum_sh;
      acc_lo <= {sum[DIGIT_W-1:0], acc_lo[MPLIER_W-1:DIGIT_W]};
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {acc_hi[MCAND_W-1:0], acc_lo};

  `SDM_ASSERT_IMP(a_no_restart, req.start, !busy, "multiplier restarted while busy")

endmodule

// File: hw/rtl/stereo_ducker_mixer.sv
// -----------------------------------------------------------------------------
// stereo_ducker_mixer
// Envelope-driven ducking of a wet stereo pair and dry/wet mix, built on two
// digit-serial multiplier lanes (left and right).
// -----------------------------------------------------------------------------
// Each item takes four multiply passes (envelope, scale, duck, mix) in the
//   4-bit-digit multipliers with ducking on, and only the mix pass with
//   duck_scale at zero (envelope held, wet passed unscaled). The input side
//   takes a new item only after the last result is pushed to the output register.
// The output register frees the input side while a result waits.
// Reset (rst, synchronous): registers back to defaults, envelope cleared.
// -----------------------------------------------------------------------------
`include "stereo_ducker_mixer_assert.svh"

module stereo_ducker_mixer import sdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // config write port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input item
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // dry_left, dry_right, wet_left, wet_right
  input  logic        s_axis_tuser,  // stereo
  // result item
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata   // out_left, out_right
);

  state_t state, state_next;

  logic [15:0] attack_coeff, release_coeff, duck_scale, wet_amount;
  logic [15:0] env;

  logic signed [15:0] dry_l, dry_r, wet_l, wet_r;
  logic signed [15:0] res_l, res_r;
  logic [15:0]        peak;
  logic               up;
  logic [15:0]        red;
  logic               out_valid;
  logic [31:0]        out_data;

  mul_req_t req_l, req_r;
  mul_rsp_t rsp_l, rsp_r;

  logic        in_acc;
  logic        up_c;
  logic [15:0] diff_c;
  logic [15:0] w_eff;
  logic [15:0] step_c;
  logic [15:0] red_c;
  logic [29:0] rdiff;
  logic signed [15:0] in_dl, in_dr;
  logic [15:0] mag_l, mag_r;
  logic signed [16:0] duck_l, duck_r;
  logic signed [18:0] mix_l, mix_r;
  logic        push;

  function automatic logic signed [15:0] sat16(input logic signed [18:0] v);
    logic signed [15:0] r;
    if (v > 19'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -19'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign push          = (state == ST_PUSH) && (!out_valid || m_axis_tready);

  // input magnitudes; right channel reads as zero in mono
  assign in_dl = s_axis_tdata[15:0];
  assign in_dr = s_axis_tuser ? s_axis_tdata[31:16] : 16'sd0;
  assign mag_l = in_dl[15] ? 16'(~in_dl + 16'sd1) : in_dl;
  assign mag_r = in_dr[15] ? 16'(~in_dr + 16'sd1) : in_dr;

  always_comb begin
    up_c   = peak > env;
    diff_c = up_c ? (peak - env) : (env - peak);
    w_eff  = (wet_amount > ONE_Q15) ? ONE_Q15 : wet_amount;
    // rounded envelope step, >> 16
    step_c = rsp_l.prod[31:16] + 16'(rsp_l.prod[15]);
    // 1 - env*duck_scale, rounded to Q1.15, floored at zero
    rdiff  = 30'h2000_2000 - rsp_l.prod[29:0];
    red_c  = (rsp_l.prod[33:29] == '0) ? rdiff[29:14] : 16'd0;
    duck_l = rsp_l.prod[31:15] + 17'(rsp_l.prod[14]);
    duck_r = rsp_r.prod[31:15] + 17'(rsp_r.prod[14]);
    // dry + (wet - dry) * w, rounded
    mix_l  = 19'(dry_l) + rsp_l.prod[33:15] + 19'(rsp_l.prod[14]);
    mix_r  = 19'(dry_r) + rsp_r.prod[33:15] + 19'(rsp_r.prod[14]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_l      = '0;
    req_r      = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (duck_scale != 16'd0) ? ST_ENV_GO : ST_MIX_GO;
        end
      end
      ST_ENV_GO: begin
        req_l.start  = 1'b1;
        req_l.mcand  = MCAND_W'(diff_c);
        req_l.mplier = up_c ? attack_coeff : release_coeff;
        state_next   = ST_ENV_WAIT;
      end
      ST_ENV_WAIT: begin
        if (rsp_l.done) begin
          state_next = ST_SCL_GO;
        end
      end
      ST_SCL_GO: begin
        req_l.start  = 1'b1;
        req_l.mcand  = MCAND_W'(env);
        req_l.mplier = duck_scale;
        state_next   = ST_SCL_WAIT;
      end
      ST_SCL_WAIT: begin
        if (rsp_l.done) begin
          state_next = ST_DUCK_GO;
        end
      end
      ST_DUCK_GO: begin
        req_l.start  = 1'b1;
        req_l.mcand  = MCAND_W'(wet_l);
        req_l.mplier = red;
        req_r.start  = 1'b1;
        req_r.mcand  = MCAND_W'(wet_r);
        req_r.mplier = red;
        state_next   = ST_DUCK_WAIT;
      end
      ST_DUCK_WAIT: begin
        if (rsp_l.done) begin
          state_next = ST_MIX_GO;
        end
      end
      ST_MIX_GO: begin
        req_l.start  = 1'b1;
        req_l.mcand  = MCAND_W'(wet_l) - MCAND_W'(dry_l);
        req_l.mplier = w_eff;
        req_r.start  = 1'b1;
        req_r.mcand  = MCAND_W'(wet_r) - MCAND_W'(dry_r);
        req_r.mplier = w_eff;
        state_next   = ST_MIX_WAIT;
      end
      ST_MIX_WAIT: begin
        if (rsp_l.done) begin
          state_next = ST_PUSH;
        end
      end
      ST_PUSH: begin
        if (push) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // config registers and envelope
  always_ff @(posedge clk) begin
    if (rst) begin
      attack_coeff  <= ATTACK_RST;
      release_coeff <= RELEASE_RST;
      duck_scale    <= DUCK_RST;
      wet_amount    <= WET_RST;
      env           <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ATTACK:  attack_coeff  <= cfg_data;
          REG_RELEASE: release_coeff <= cfg_data;
          REG_DUCK:    duck_scale    <= cfg_data;
          REG_WET:     wet_amount    <= cfg_data;
          default:     ;
        endcase
      end
      if (state == ST_ENV_WAIT && rsp_l.done) begin
        env <= up ? (env + step_c) : (env - step_c);
      end
    end
  end

  // item datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dry_l <= in_dl;
      dry_r <= in_dr;
      wet_l <= s_axis_tdata[47:32];
      wet_r <= s_axis_tuser ? s_axis_tdata[63:48] : 16'sd0;
      peak  <= (mag_r > mag_l) ? mag_r : mag_l;
    end
    if (state == ST_ENV_GO) begin
      up <= up_c;
    end
    if (state == ST_SCL_WAIT && rsp_l.done) begin
      red <= red_c;
    end
    if (state == ST_DUCK_WAIT && rsp_l.done) begin
      wet_l <= duck_l[15:0];
      wet_r <= duck_r[15:0];
    end
    if (state == ST_MIX_WAIT && rsp_l.done) begin
      res_l <= sat16(mix_l);
      res_r <= sat16(mix_r);
    end
    if (push) begin
      out_data <= {res_r, res_l};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  sdm_mul u_mul_l (
    .clk (clk),
    .rst (rst),
    .req (req_l),
    .rsp (rsp_l)
  );

  sdm_mul u_mul_r (
    .clk (clk),
    .rst (rst),
    .req (req_r),
    .rsp (rsp_r)
  );

  `SDM_ASSERT_IMP(a_env_range, 1'b1, env <= ONE_Q15, "envelope above unity")
  `SDM_ASSERT_IMP(a_done_in_wait, rsp_l.done || rsp_r.done, state == ST_ENV_WAIT || state == ST_SCL_WAIT || state == ST_DUCK_WAIT || state == ST_MIX_WAIT, "multiplier result outside a wait state")
  `SDM_ASSERT_IMP(a_lanes_lockstep, rsp_r.done, rsp_l.done, "right lane out of step")
  `SDM_ASSERT_NXT(a_accept_busy, in_acc, state != ST_IDLE, "accepted item left no work")

endmodule

// File: dv/stereo_ducker_mixer_chk.sv
// ----------------------------------------------------------------------------
// stereo_ducker_mixer_chk
// Passive checker for the ducker/mixer. It follows the register writes and
// the input items, predicts each mixed output pair with its own envelope
// follower, and compares it field by field against the result stream.
// ----------------------------------------------------------------------------
module stereo_ducker_mixer_chk import sdm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,  // dry_left, dry_right, wet_left, wet_right
  input  logic        s_axis_tuser,  // stereo
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,  // out_left, out_right
  output int unsigned pending,
  output int unsigned fail_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint UNITY = longint'(ONE_Q15);

  typedef struct packed {
    logic [15:0] right;
    logic [15:0] left;
  } mix_pair_t;

  mix_pair_t   mix_q[$];
  longint      atk_c, rel_c, duck_c, wet_c;
  longint      env;
  int unsigned err_cnt = 0;

  initial begin
    pending = 0;
    fail_count = 0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  // add half an LSB, then floor
  function automatic longint rnd_shift(input longint v, input int s);
    return (v + (longint'(1) << (s - 1))) >>> s;
  endfunction

  function automatic logic [15:0] sat16(input longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  function automatic longint mag(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // advances the envelope as a side effect
  function automatic mix_pair_t duck_and_mix(input logic [63:0] d, input logic st);
    longint    dl, dr, wl, wr, w, pk, delta, diff, red;
    mix_pair_t r;
    dl = $signed(d[15:0]);
    dr = st ? longint'($signed(d[31:16])) : 0;
    wl = $signed(d[47:32]);
    wr = st ? longint'($signed(d[63:48])) : 0;
    w  = (wet_c > UNITY) ? UNITY : wet_c;
    if (duck_c != 0) begin
      pk = mag(dl);
      if (st && mag(dr) > pk) pk = mag(dr);
      if (pk > env) begin
        delta = pk - env;
        env   = env + ((delta * atk_c + 32768) >>> 16);
      end else begin
        delta = env - pk;
        env   = env - ((delta * rel_c + 32768) >>> 16);
      end
      diff = (longint'(1) << 29) - env * duck_c;
      red  = (diff > 0) ? rnd_shift(diff, 14) : 0;
      wl   = rnd_shift(wl * red, 15);
      wr   = rnd_shift(wr * red, 15);
    end
    r.left  = sat16(rnd_shift(dl * (UNITY - w) + wl * w, 15));
    r.right = st ? sat16(rnd_shift(dr * (UNITY - w) + wr * w, 15)) : 16'h0000;
    return r;
  endfunction

  always @(posedge clk) begin
    mix_pair_t want;
    if (rst) begin
      atk_c  = longint'(ATTACK_RST);
      rel_c  = longint'(RELEASE_RST);
      duck_c = longint'(DUCK_RST);
      wet_c  = longint'(WET_RST);
      env    = 0;
      mix_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_ATTACK:  atk_c  = longint'(cfg_data);
          REG_RELEASE: rel_c  = longint'(cfg_data);
          REG_DUCK:    duck_c = longint'(cfg_data);
          REG_WET:     wet_c  = longint'(cfg_data);
          default: ;
        endcase
      end
      // results first, so an item accepted this edge never matches one leaving
      if (m_axis_tvalid && m_axis_tready) begin
        if (mix_q.size() == 0) begin
          flag_error($sformatf("result %h arrived with none expected", m_axis_tdata));
        end else begin
          want = mix_q.pop_front();
          if (m_axis_tdata[15:0] !== want.left)
            flag_error($sformatf("out_left %h, expected %h", m_axis_tdata[15:0], want.left));
          if (m_axis_tdata[31:16] !== want.right)
            flag_error($sformatf("out_right %h, expected %h", m_axis_tdata[31:16],
                                 want.right));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        mix_q.push_back(duck_and_mix(s_axis_tdata, s_axis_tuser));
    end
    pending    <= mix_q.size();
    fail_count <= err_cnt;
  end

endmodule

// File: dv/stereo_ducker_mixer_tb.sv
// ----------------------------------------------------------------------------
// stereo_ducker_mixer_tb
// Stimulus and verdict for the ducker/mixer. Directed corner items at several
// register settings, then random phases of level-shaped audio with random
// register settings, random input gaps and random output back-pressure.
// ----------------------------------------------------------------------------
module stereo_ducker_mixer_tb import sdm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ATTACK;
  logic [15:0] cfg_data = 16'h0000;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata = 64'h0;  // dry_left, dry_right, wet_left, wet_right
  logic        s_axis_tuser = 1'b0;   // stereo
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;          // out_left, out_right

  int unsigned pending;
  int unsigned fail_count;
  bit          src_idle = 1'b1;
  bit          sink_stall = 1'b1;
  int unsigned stall_left = 0;

  always #10 clk = ~clk;

  stereo_ducker_mixer dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  stereo_ducker_mixer_chk chk (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .pending, .fail_count
  );

  // output back-pressure: mostly short stalls, a few long ones
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (sink_stall && $urandom_range(0, 9) == 0) begin
      stall_left    <= ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80)
                                                   : $urandom_range(0, 3);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!src_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // called right after a rising edge; returns on the accepting edge or after the gap
  task automatic send_item(input logic [15:0] dl, input logic [15:0] dr,
                           input logic [15:0] wl, input logic [15:0] wr,
                           input logic st);
    int unsigned gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {wr, wl, dr, dl};
    s_axis_tuser  <= st;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    gap = pick_gap();
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // wait out every outstanding result, then the ducking-on latency
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] atk, input logic [15:0] rel,
                              input logic [15:0] duck, input logic [15:0] wet);
    write_reg(REG_ATTACK, atk);
    write_reg(REG_RELEASE, rel);
    write_reg(REG_DUCK, duck);
    write_reg(REG_WET, wet);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [15:0] pick_coeff();
    case ($urandom_range(0, 4))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_duck();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd40960;
      2:       return 16'hFFFF;  // beyond the nominal range
      3:       return 16'($urandom_range(1, 2048));
      4:       return 16'($urandom_range(40961, 65535));
      default: return 16'($urandom_range(1, 40960));
    endcase
  endfunction

  function automatic logic [15:0] pick_wet();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd32768;
      2:       return 16'hFFFF;
      3:       return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(0, 32768));
    endcase
  endfunction

  // level sets loudness so the envelope sees attack and release stretches
  function automatic logic [15:0] sample16(input int unsigned level);
    case ($urandom_range(0, 19))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($signed(16'($urandom)) >>> level);
    endcase
  endfunction

  initial begin
    int unsigned level;
    level = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset values: ducking off, half wet
    send_item(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_item(16'h7FFF, 16'h8000, 16'h8000, 16'h7FFF, 1'b1);
    send_item(16'h1234, 16'h7FFF, 16'h8000, 16'h8000, 1'b0);  // mono, right junk
    send_item(16'hFFFF, 16'h0001, 16'h0001, 16'hFFFF, 1'b1);
    drain();

    // instant attack/release, full depth, all wet
    program_regs(16'hFFFF, 16'hFFFF, 16'd40960, 16'd32768);
    send_item(16'h8000, 16'h0001, 16'h7FFF, 16'h8000, 1'b1);  // reduction bottoms out
    send_item(16'h0000, 16'h8000, 16'h7FFF, 16'h7FFF, 1'b0);
    send_item(16'h0000, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b1);
    send_item(16'h0001, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1);
    send_item(16'h4000, 16'hC000, 16'h7FFF, 16'h8000, 1'b1);
    drain();

    // envelope frozen by zero coefficients, depth past range, wet share clipped
    program_regs(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
    send_item(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
    send_item(16'h8000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
    send_item(16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF, 1'b1);
    send_item(16'h2000, 16'hE000, 16'h4000, 16'hC000, 1'b1);
    drain();

    // nominal time constants, all dry
    program_regs(ATTACK_RST, RELEASE_RST, 16'd16384, 16'd0);
    send_item(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    send_item(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_item(16'h0000, 16'h0000, 16'h7FFF, 16'h8000, 1'b1);
    send_item(16'h8000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    drain();

    for (int p = 0; p < 8; p++) begin
      program_regs(pick_coeff(), pick_coeff(), pick_duck(), pick_wet());
      src_idle = (p % 4 != 3);
      sink_stall <= (p % 4 != 3);
      for (int n = 0; n < 175; n++) begin
        if ($urandom_range(0, 15) == 0) level = $urandom_range(0, 15);
        send_item(sample16(level), sample16(level), sample16(level), sample16(level),
                  $urandom_range(0, 3) != 0);
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #(20_000_000);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
